### rtl/lstc_pkg.sv
`timescale 1ns / 1ps

package lstc_pkg;

  // Snapshot queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int QW          = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FW          = $clog2(QUEUE_DEPTH + 1);

  // Operation codes
  localparam logic OP_CORRECT = 1'b0;
  localparam logic OP_RECORD  = 1'b1;

  // Kernel leap states that change a timestamp
  localparam logic [2:0] LS_INSERT   = 3'd1;
  localparam logic [2:0] LS_IN_PROG  = 3'd3;
  localparam logic [2:0] LS_WAIT     = 3'd4;

  // Arithmetic constants
  localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
  localparam logic [16:0] LAST_SEC     = 17'd86399;
  localparam logic [13:0] FOLD_MUL     = 14'd11776;       // 2^20 mod 86400
  localparam logic [15:0] DAY_RECIP    = 16'd49710;       // floor(2^32 / 86400)
  localparam logic [30:0] DIV1000_MUL  = 31'd1099511628;  // ceil(2^40 / 1000)
  localparam logic [19:0] MAX_USEC     = 20'd999999;
  localparam logic [30:0] LEAP_IND     = 31'd1000000000;

  // Sequencer timing: cycles after acceptance until datapath results settle
  localparam int         CNT_W     = 3;
  localparam logic [2:0] REC_DONE  = 3'd2;
  localparam logic [2:0] CORR_DONE = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REC,
    ST_CORR
  } lstc_state_t;

  typedef struct packed {
    logic [47:0] index;
    logic [39:0] sec;
    logic [19:0] usec;
    logic [2:0]  state;
  } lstc_snap_t;

  typedef struct packed {
    logic load;   // capture input item
    logic count;  // advance running count
    logic push;   // store snapshot
    logic pop;    // drop queue front
    logic emit;   // register a result
  } lstc_cmd_t;

  typedef struct packed {
    logic pop_needed;
    logic queue_empty;
    logic queue_full;
    logic out_valid;
    logic overflow;
  } lstc_status_t;

endpackage

### rtl/leap_second_timestamp_corrector_unit.sv
`timescale 1ns / 1ps
// A correct item gives its result once the second-of-day reduction has settled,
// each expired snapshot is popped (one pop per cycle) and the output is free.
// One item is taken at a time: a record or correct item must finish before the
// next is accepted.
// Reset (rst_n, synchronous, active low) empties the queue and clears the count.

module leap_second_timestamp_corrector_unit
  import lstc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [39:0] in_ts_sec,
  input  logic [29:0] in_ts_nsec,
  input  logic [47:0] in_rec_index,
  input  logic [39:0] in_clk_sec,
  input  logic [29:0] in_clk_frac,
  input  logic        in_clk_nano,
  input  logic [2:0]  in_clk_state,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [39:0] out_sec,
  output logic [30:0] out_nsec,
  output logic        out_leap_marked,
  output logic        out_overflow_seen
);

  lstc_cmd_t    cmd;
  lstc_status_t st;

  lstc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_op),
    .out_ready (out_ready),
    .st        (st),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  lstc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_ts_sec         (in_ts_sec),
    .in_ts_nsec        (in_ts_nsec),
    .in_rec_index      (in_rec_index),
    .in_clk_sec        (in_clk_sec),
    .in_clk_frac       (in_clk_frac),
    .in_clk_nano       (in_clk_nano),
    .in_clk_state      (in_clk_state),
    .out_ready         (out_ready),
    .st                (st),
    .out_valid         (out_valid),
    .out_sec           (out_sec),
    .out_nsec          (out_nsec),
    .out_leap_marked   (out_leap_marked),
    .out_overflow_seen (out_overflow_seen)
  );

  // One item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while busy");

  // Never pop an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> !st.queue_empty)
    else $error("pop from empty queue");

  // Dropped snapshot raises the sticky flag
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && st.queue_full) |=> st.overflow)
    else $error("overflow not flagged");

  // Never overwrite a result still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!st.out_valid || out_ready))
    else $error("result overwritten");

endmodule

### rtl/lstc_ctrl.sv
`timescale 1ns / 1ps

module lstc_ctrl
  import lstc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_op,
  input  logic         out_ready,
  input  lstc_status_t st,
  output logic         in_ready,
  output lstc_cmd_t    cmd
);

  lstc_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             corr_done;

  // Result may leave once arithmetic has settled, the queue is trimmed and
  // the output register is free
  assign corr_done = (cnt_r >= CORR_DONE) && !st.pop_needed &&
                     (!st.out_valid || out_ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_op == OP_RECORD) ? ST_REC : ST_CORR;
        end
      end
      ST_REC: begin
        if (cnt_r == REC_DONE) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CORR: begin
        if (corr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Settling counter: clear while idle, saturate at the longest wait
  always_comb begin
    if (state_r == ST_IDLE) begin
      cnt_nxt = '0;
    end else if (cnt_r < CORR_DONE) begin
      cnt_nxt = cnt_r + 1'b1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // Commands
  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.load  = in_valid;
        cmd.count = in_valid && (in_op == OP_CORRECT);
      end
      ST_REC: begin
        cmd.push = (cnt_r == REC_DONE);
      end
      ST_CORR: begin
        cmd.pop  = st.pop_needed;
        cmd.emit = corr_done;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### rtl/lstc_dp.sv
`timescale 1ns / 1ps

module lstc_dp
  import lstc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  lstc_cmd_t    cmd,
  input  logic [39:0]  in_ts_sec,
  input  logic [29:0]  in_ts_nsec,
  input  logic [47:0]  in_rec_index,
  input  logic [39:0]  in_clk_sec,
  input  logic [29:0]  in_clk_frac,
  input  logic         in_clk_nano,
  input  logic [2:0]   in_clk_state,
  input  logic         out_ready,
  output lstc_status_t st,
  output logic         out_valid,
  output logic [39:0]  out_sec,
  output logic [30:0]  out_nsec,
  output logic         out_leap_marked,
  output logic         out_overflow_seen
);

  // Captured item
  logic [39:0] ts_sec_r;
  logic [29:0] ts_nsec_r;
  logic [47:0] rec_index_r;
  logic [39:0] clk_sec_r;
  logic [29:0] clk_frac_r;
  logic        clk_nano_r;
  logic [2:0]  clk_state_r;

  // Arithmetic pipeline
  logic [33:0] x1_r;
  logic [27:0] x2_r;
  logic [21:0] x3_r, x3d_r;
  logic [37:0] qp_r;
  logic [17:0] r1_r;
  logic        sod_last_r, sod_zero_r;
  logic [60:0] pts_r, pclk_r;
  logic [20:0] tus_r;
  logic [19:0] live_usec_r;
  logic [39:0] sec_m1_r;
  logic [30:0] nsec_p_r;

  logic [21:0] r1_full;
  logic [16:0] sod;
  logic [29:0] usec_raw;

  // Queue
  lstc_snap_t mem [QUEUE_DEPTH];
  lstc_snap_t rd_r;
  logic [QW-1:0] head_r, head_nxt, tail;
  logic [FW-1:0] fill_r;
  logic [QW+1:0] tail_sum;
  logic          ovf_r;
  logic [47:0]   count_r;
  logic          q_empty, q_full;

  // Result
  logic        out_valid_r;
  logic [39:0] out_sec_r;
  logic [30:0] out_nsec_r;
  logic        leap_r, ovf_out_r;

  logic        use_snap, later, leap, back;
  logic [2:0]  rstate;
  logic [39:0] rsec;
  logic [19:0] rusec;

  // Capture item fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ts_sec_r    <= in_ts_sec;
      ts_nsec_r   <= in_ts_nsec;
      rec_index_r <= in_rec_index;
      clk_sec_r   <= in_clk_sec;
      clk_frac_r  <= in_clk_frac;
      clk_nano_r  <= in_clk_nano;
      clk_state_r <= in_clk_state;
    end
  end

  // Second of day: fold the upper bits down three times, then reduce by
  // reciprocal estimate and one corrective subtract
  assign r1_full = x3d_r - 22'(qp_r[37:32]) * 22'(SEC_PER_DAY);
  assign sod     = (r1_r >= 18'(SEC_PER_DAY)) ? 17'(r1_r - 18'(SEC_PER_DAY))
                                              : r1_r[16:0];

  // Microseconds of the live clock fraction
  assign usec_raw = clk_nano_r ? 30'(pclk_r[60:40]) : clk_frac_r;

  always_ff @(posedge clk) begin
    x1_r        <= 34'(ts_sec_r[39:20]) * 34'(FOLD_MUL) + 34'(ts_sec_r[19:0]);
    x2_r        <= 28'(x1_r[33:20]) * 28'(FOLD_MUL) + 28'(x1_r[19:0]);
    x3_r        <= 22'(x2_r[27:20]) * 22'(FOLD_MUL) + 22'(x2_r[19:0]);
    qp_r        <= 38'(x3_r) * 38'(DAY_RECIP);
    x3d_r       <= x3_r;
    r1_r        <= r1_full[17:0];
    sod_last_r  <= (sod == LAST_SEC);
    sod_zero_r  <= (sod == 17'd0);
    pts_r       <= 61'(ts_nsec_r) * 61'(DIV1000_MUL);
    pclk_r      <= 61'(clk_frac_r) * 61'(DIV1000_MUL);
    tus_r       <= pts_r[60:40];
    live_usec_r <= (usec_raw > 30'(MAX_USEC)) ? MAX_USEC : usec_raw[19:0];
    sec_m1_r    <= ts_sec_r - 40'd1;
    nsec_p_r    <= 31'(ts_nsec_r) + LEAP_IND;
  end

  // Queue pointers
  assign q_empty  = (fill_r == '0);
  assign q_full   = (fill_r == FW'(QUEUE_DEPTH));
  assign tail_sum = (QW+2)'(head_r) + (QW+2)'(fill_r);
  assign tail     = (tail_sum >= (QW+2)'(QUEUE_DEPTH)) ?
                    QW'(tail_sum - (QW+2)'(QUEUE_DEPTH)) : tail_sum[QW-1:0];

  always_comb begin
    head_nxt = head_r;
    if (cmd.pop) begin
      head_nxt = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      fill_r  <= '0;
      ovf_r   <= 1'b0;
      count_r <= '0;
    end else begin
      head_r <= head_nxt;
      if (cmd.count) begin
        count_r <= count_r + 48'd1;
      end
      if (cmd.push) begin
        if (q_full) begin
          ovf_r <= 1'b1;
        end else begin
          fill_r <= fill_r + 1'b1;
        end
      end else if (cmd.pop) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  // Snapshot store: write at tail, read the next front
  always_ff @(posedge clk) begin
    if (cmd.push && !q_full) begin
      mem[tail] <= '{index: rec_index_r, sec: clk_sec_r,
                     usec: live_usec_r, state: clk_state_r};
    end
    rd_r <= mem[head_nxt];
  end

  // Reference selection and leap rules
  assign use_snap = !q_empty;
  assign rstate   = use_snap ? rd_r.state : clk_state_r;
  assign rsec     = use_snap ? rd_r.sec   : clk_sec_r;
  assign rusec    = use_snap ? rd_r.usec  : live_usec_r;
  assign later    = (ts_sec_r > rsec) ||
                    ((ts_sec_r == rsec) && (tus_r > 21'(rusec)));

  always_comb begin
    leap = 1'b0;
    back = 1'b0;
    case (rstate)
      LS_WAIT: begin
        leap = sod_last_r;
      end
      LS_IN_PROG: begin
        if (later) begin
          leap = sod_zero_r;
          back = sod_zero_r;
        end else begin
          leap = sod_last_r;
        end
      end
      LS_INSERT: begin
        leap = sod_zero_r;
        back = sod_zero_r;
      end
      default: begin
        leap = 1'b0;
      end
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sec_r  <= back ? sec_m1_r : ts_sec_r;
      out_nsec_r <= leap ? nsec_p_r : 31'(ts_nsec_r);
      leap_r     <= leap;
      ovf_out_r  <= ovf_r;
    end
  end

  assign st.pop_needed  = !q_empty && (rd_r.index < count_r);
  assign st.queue_empty = q_empty;
  assign st.queue_full  = q_full;
  assign st.out_valid   = out_valid_r;
  assign st.overflow    = ovf_r;

  assign out_valid         = out_valid_r;
  assign out_sec           = out_sec_r;
  assign out_nsec          = out_nsec_r;
  assign out_leap_marked   = leap_r;
  assign out_overflow_seen = ovf_out_r;

endmodule

### tb/sv/leap_second_timestamp_corrector_unit_tb.sv
`timescale 1ns / 1ps

module leap_second_timestamp_corrector_unit_tb
  import lstc_pkg::*;
();

  // Leap states that pass a timestamp through
  localparam logic [2:0] LS_OK     = 3'd0;
  localparam logic [2:0] LS_DELETE = 3'd2;
  localparam logic [2:0] LS_ERROR  = 3'd5;

  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYCLES  = 40;

  typedef struct {
    logic        op;
    logic [39:0] ts_sec;
    logic [29:0] ts_nsec;
    logic [47:0] rec_index;
    logic [39:0] clk_sec;
    logic [29:0] clk_frac;
    logic        clk_nano;
    logic [2:0]  clk_state;
    bit          drain;
  } stamp_item_t;

  typedef struct {
    logic [39:0] sec;
    logic [30:0] nsec;
    logic        leap;
    logic        ovf;
  } stamp_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = 1'b0;
  logic [39:0] in_ts_sec = '0;
  logic [29:0] in_ts_nsec = '0;
  logic [47:0] in_rec_index = '0;
  logic [39:0] in_clk_sec = '0;
  logic [29:0] in_clk_frac = '0;
  logic        in_clk_nano = 1'b0;
  logic [2:0]  in_clk_state = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [39:0] out_sec;
  logic [30:0] out_nsec;
  logic        out_leap_marked;
  logic        out_overflow_seen;

  leap_second_timestamp_corrector_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_ts_sec         (in_ts_sec),
    .in_ts_nsec        (in_ts_nsec),
    .in_rec_index      (in_rec_index),
    .in_clk_sec        (in_clk_sec),
    .in_clk_frac       (in_clk_frac),
    .in_clk_nano       (in_clk_nano),
    .in_clk_state      (in_clk_state),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sec           (out_sec),
    .out_nsec          (out_nsec),
    .out_leap_marked   (out_leap_marked),
    .out_overflow_seen (out_overflow_seen)
  );

  stamp_item_t   pending_items[$];
  stamp_result_t expected_stamps[$];
  lstc_snap_t    snapshot_fifo[$];
  stamp_item_t   bus_item;

  logic [47:0] model_count = '0;
  logic        overflow_sticky = 1'b0;
  logic [47:0] gen_corrects = '0;
  bit          drain_next = 1'b0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          cycles = 0;
  int          burst_left = 1;
  int          gap_left = 0;

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Reset, held low at the start of the run
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [19:0] frac_to_usec(logic [29:0] frac, logic nano);
    logic [29:0] u;
    u = nano ? (frac / 30'd1000) : frac;
    if (u > 30'(MAX_USEC)) u = 30'(MAX_USEC);
    return u[19:0];
  endfunction

  // Advance the predicted state by one accepted item
  task automatic predict_correction(input stamp_item_t it);
    lstc_snap_t    ref_snap;
    stamp_result_t res;
    logic [39:0]   sod;
    logic [29:0]   ts_usec;
    logic          later;
    if (it.op == OP_RECORD) begin
      if (snapshot_fifo.size() >= QUEUE_DEPTH) begin
        overflow_sticky = 1'b1;
      end else begin
        ref_snap.index = it.rec_index;
        ref_snap.sec   = it.clk_sec;
        ref_snap.usec  = frac_to_usec(it.clk_frac, it.clk_nano);
        ref_snap.state = it.clk_state;
        snapshot_fifo.push_back(ref_snap);
      end
    end else begin
      model_count = model_count + 48'd1;
      // drop snapshots that no longer apply
      while (snapshot_fifo.size() != 0 && snapshot_fifo[0].index < model_count)
        void'(snapshot_fifo.pop_front());
      res.sec  = it.ts_sec;
      res.nsec = {1'b0, it.ts_nsec};
      res.leap = 1'b0;
      sod = it.ts_sec % SEC_PER_DAY;
      if (sod == LAST_SEC || sod == 40'd0) begin
        if (snapshot_fifo.size() != 0) begin
          ref_snap = snapshot_fifo[0];
        end else begin
          ref_snap.index = '0;
          ref_snap.sec   = it.clk_sec;
          ref_snap.usec  = frac_to_usec(it.clk_frac, it.clk_nano);
          ref_snap.state = it.clk_state;
        end
        case (ref_snap.state)
          LS_WAIT: begin
            res.leap = (sod == LAST_SEC);
          end
          LS_IN_PROG: begin
            ts_usec = it.ts_nsec / 30'd1000;
            later = (it.ts_sec > ref_snap.sec) ||
                    (it.ts_sec == ref_snap.sec && ts_usec > 30'(ref_snap.usec));
            if (later) begin
              if (sod == 40'd0) begin
                res.sec  = it.ts_sec - 40'd1;
                res.leap = 1'b1;
              end
            end else if (sod == LAST_SEC) begin
              res.leap = 1'b1;
            end
          end
          LS_INSERT: begin
            if (sod == 40'd0) begin
              res.sec  = it.ts_sec - 40'd1;
              res.leap = 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (res.leap) res.nsec = res.nsec + LEAP_IND;
      res.ovf = overflow_sticky;
      expected_stamps.push_back(res);
    end
  endtask

  task automatic queue_record(logic [47:0] idx, logic [39:0] csec, logic [29:0] cfrac,
                              logic cnano, logic [2:0] cst);
    stamp_item_t it;
    logic [63:0] r;
    r = rand64();
    it.op        = OP_RECORD;
    it.ts_sec    = r[39:0];
    it.ts_nsec   = r[63:34];
    it.rec_index = idx;
    it.clk_sec   = csec;
    it.clk_frac  = cfrac;
    it.clk_nano  = cnano;
    it.clk_state = cst;
    it.drain     = drain_next;
    drain_next   = 1'b0;
    pending_items.push_back(it);
  endtask

  task automatic queue_correct(logic [39:0] tsec, logic [29:0] tnsec, logic [39:0] csec,
                               logic [29:0] cfrac, logic cnano, logic [2:0] cst);
    stamp_item_t it;
    it.op        = OP_CORRECT;
    it.ts_sec    = tsec;
    it.ts_nsec   = tnsec;
    it.rec_index = 48'(rand64());
    it.clk_sec   = csec;
    it.clk_frac  = cfrac;
    it.clk_nano  = cnano;
    it.clk_state = cst;
    it.drain     = drain_next;
    drain_next   = 1'b0;
    pending_items.push_back(it);
    gen_corrects = gen_corrects + 48'd1;
  endtask

  function automatic logic [2:0] pick_state();
    case ($urandom_range(0, 9))
      0, 1, 2: return LS_INSERT;
      3, 4, 5: return LS_IN_PROG;
      6, 7:    return LS_WAIT;
      default: return 3'($urandom_range(0, 7));
    endcase
  endfunction

  // Clock fraction close to a given microsecond value, or now and then a random one
  function automatic logic [29:0] frac_near(int unsigned usec, logic nano);
    if ($urandom_range(0, 15) == 0) return 30'($urandom);
    if (nano) return 30'(usec * 1000 + $urandom_range(0, 999));
    return 30'(usec);
  endfunction

  // One leap-second scenario: snapshots near a day boundary, then timestamps around it
  task automatic queue_leap_sequence();
    longint unsigned bnd;
    int unsigned     usec;
    int unsigned     nrec;
    int unsigned     ncor;
    int              ns;
    logic            nano;
    logic [47:0]     idx;
    bnd  = longint'($urandom_range(1, 12725828)) * 86400;
    usec = $urandom_range(0, 999999);
    nrec = $urandom_range(0, 4);
    ncor = $urandom_range(1, 5);
    idx  = gen_corrects + 48'($urandom_range(0, 1));
    for (int i = 0; i < nrec; i++) begin
      nano = 1'($urandom_range(0, 1));
      queue_record(idx, 40'(bnd + $urandom_range(0, 2) - 1), frac_near(usec, nano), nano,
                   pick_state());
      idx = idx + 48'($urandom_range(0, 2));
    end
    for (int i = 0; i < ncor; i++) begin
      nano = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) ns = $urandom_range(0, 30'h3FFF_FFFF);
      else ns = int'(usec) * 1000 + $urandom_range(0, 4000) - 2000;
      if (ns < 0) ns = 0;
      queue_correct(40'(bnd + $urandom_range(0, 3) - 2), 30'(ns),
                    40'(bnd + $urandom_range(0, 2) - 1), frac_near(usec, nano), nano,
                    pick_state());
    end
  endtask

  // Unstructured item with full-range fields
  task automatic queue_noise();
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    a = rand64();
    b = rand64();
    c = rand64();
    if (a[63]) begin
      queue_record(gen_corrects + 48'($urandom_range(0, 3)), b[39:0], c[29:0], c[30],
                   c[34:32]);
    end else begin
      if ($urandom_range(0, 3) == 0) a[39:0] = 40'($urandom_range(0, 12725828)) * 40'd86400;
      queue_correct(a[39:0], a[61:32] ^ b[61:32], b[39:0], c[29:0], c[30], c[34:32]);
    end
  endtask

  // Stimulus and end of run
  initial begin
    int unsigned   made;
    longint unsigned bnd;
    logic [2:0]    pass_states[5];
    pass_states = '{LS_OK, LS_DELETE, LS_ERROR, 3'd6, 3'd7};

    // Directed part
    queue_correct(40'd0, 30'd0, 40'd12345, 30'd17, 1'b0, LS_INSERT);
    queue_correct(40'd86399, 30'd999999999, 40'd86400, 30'd0, 1'b0, LS_WAIT);
    queue_correct(40'hFF_FFFF_FFFF, 30'h3FFF_FFFF, 40'hFF_FFFF_FFFF, 30'h3FFF_FFFF, 1'b1,
                  3'd7);
    queue_correct(40'd86400, 30'd123456789, 40'd86399, 30'd999999, 1'b0, LS_IN_PROG);
    queue_correct(40'd86399, 30'd5, 40'd86400, 30'd0, 1'b1, LS_IN_PROG);
    queue_correct(40'd172799, 30'd500000000, 40'd172799, 30'd500000000, 1'b1, LS_IN_PROG);
    queue_correct(40'd172799, 30'd500001000, 40'd172799, 30'd500000000, 1'b1, LS_IN_PROG);
    queue_correct(40'd259199, 30'h3FFF_FFFF, 40'd259199, 30'h3FFF_FFFF, 1'b0, LS_IN_PROG);
    queue_correct(40'd259199, 30'h3FFF_FFFF, 40'd259199, 30'h3FFF_FFFF, 1'b1, LS_IN_PROG);
    foreach (pass_states[i])
      queue_correct(40'd259200 - 40'(i % 2), 30'd42, 40'd259199, 30'd0, 1'b0, pass_states[i]);
    // snapshot at the queue front overrides the live clock
    queue_record(gen_corrects + 48'd1, 40'd345599, 30'd999999, 1'b0, LS_INSERT);
    queue_correct(40'd345600, 30'd7, 40'd345600, 30'd0, 1'b0, LS_OK);
    queue_correct(40'd345600, 30'd7, 40'd345600, 30'd0, 1'b0, LS_WAIT);
    // a burst of expired snapshots, all dropped by one correct item
    for (int i = 0; i < 8; i++)
      queue_record(gen_corrects, 40'(i), 30'(i), 1'(i), 3'(i));
    queue_correct(40'd432000, 30'd1, 40'd431999, 30'd2, 1'b0, LS_INSERT);

    // Random part: mostly leap scenarios, some noise
    made = 0;
    while (made < RANDOM_ITEMS) begin
      int unsigned before_len;
      before_len = pending_items.size();
      if (made >= RANDOM_ITEMS / 2 && made < RANDOM_ITEMS / 2 + 10) drain_next = 1'b1;
      if ($urandom_range(0, 9) < 7) queue_leap_sequence();
      else repeat ($urandom_range(1, 3)) queue_noise();
      made += pending_items.size() - before_len;
    end

    // Tail: snapshots that never expire, then a full queue
    for (int i = 0; i < QUEUE_DEPTH + 2; i++) begin
      if (i == 0) queue_record(48'hFFFF_FFFF_FFFF, 40'd518400, 30'd0, 1'b0, LS_INSERT);
      else queue_record(48'(rand64()) | 48'h8000_0000_0000, 40'(rand64()), 30'($urandom),
                        1'($urandom), pick_state());
    end
    for (int i = 0; i < 12; i++) begin
      bnd = longint'($urandom_range(1, 12725828)) * 86400;
      queue_correct(40'(bnd - $urandom_range(0, 1)), 30'($urandom_range(0, 999999999)),
                    40'(rand64()), 30'($urandom), 1'($urandom), 3'($urandom));
    end

    // Wait for all items to go in and all results to come out
    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_stamps.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Driver: offer items in bursts with random gaps
  always @(posedge clk) begin : drive_proc
    logic offer;
    offer = in_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_correction(bus_item);
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_items.size() != 0 &&
                     (!pending_items[0].drain || expected_stamps.size() == 0)) begin
          bus_item = pending_items.pop_front();
          in_op        <= bus_item.op;
          in_ts_sec    <= bus_item.ts_sec;
          in_ts_nsec   <= bus_item.ts_nsec;
          in_rec_index <= bus_item.rec_index;
          in_clk_sec   <= bus_item.clk_sec;
          in_clk_frac  <= bus_item.clk_frac;
          in_clk_nano  <= bus_item.clk_nano;
          in_clk_state <= bus_item.clk_state;
          offer = 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end
      end
      in_valid <= offer;
    end
  end

  // Receiver: stall pattern of its own, plus one long hold-off
  always @(posedge clk) begin : ready_proc
    int  hold_left;
    int  mode;
    int  phase;
    bit  long_done;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
      mode      = 0;
      phase     = 0;
      long_done = 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!long_done && results_seen >= 150) begin
      long_done = 1'b1;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      phase++;
      if (phase % 50 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 3) != 0);
        2:       out_ready <= ((phase / 4) % 2 == 0);
        default: out_ready <= $urandom_range(0, 1);
      endcase
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin : watch_proc
    stamp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_stamps.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual sec 0x%0h nsec 0x%0h",
                 $time, out_sec, out_nsec);
        mismatches++;
      end else begin
        want = expected_stamps.pop_front();
        check_field("out_sec", 64'(want.sec), 64'(out_sec));
        check_field("out_nsec", 64'(want.nsec), 64'(out_nsec));
        check_field("out_leap_marked", 64'(want.leap), 64'(out_leap_marked));
        check_field("out_overflow_seen", 64'(want.ovf), 64'(out_overflow_seen));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule

### files.f
rtl/lstc_pkg.sv
rtl/lstc_ctrl.sv
rtl/lstc_dp.sv
rtl/leap_second_timestamp_corrector_unit.sv
tb/sv/leap_second_timestamp_corrector_unit_tb.sv
